// ===== rtl/rau_pkg.sv =====
`timescale 1ns / 1ps

package rau_pkg;

    // Operation codes.
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_INV = 3'd4;
    localparam logic [2:0] OP_NEG = 3'd5;

    // Status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_SETUP,
        S_GCD,
        S_SHIFT,
        S_DIVN_GO,
        S_DIVN_WAIT,
        S_DIVD_GO,
        S_DIVD_WAIT,
        S_FIN
    } t_state;

endpackage

// ===== rtl/rau_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module rau_div #(
    parameter int WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quot
);

    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH:0]   r_rem;
    logic [WIDTH-1:0] r_quot;
    logic [WIDTH-1:0] r_dvs;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [WIDTH:0]   rem_sh;
    logic [WIDTH:0]   diff;

    // Shift in the next dividend bit and try the subtraction.
    assign rem_sh = {r_rem[WIDTH-1:0], r_quot[WIDTH-1]};
    assign diff   = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CW'(WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Dividend bits leave the top of r_quot as quotient bits enter at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            if (!diff[WIDTH]) begin
                r_rem  <= diff;
                r_quot <= {r_quot[WIDTH-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_quot <= {r_quot[WIDTH-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== rtl/rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// Sequence from request acceptance to result: four products on the shared multiplier, a setup
// state, a binary GCD on 2*VALUE_WIDTH-bit magnitudes followed by the restore of common twos,
// and two bit-serial divisions. A new request is taken while a result waits in the output,
// but not while an earlier request is still being worked on.
// Reset: synchronous active-low reset returns the sequencer to idle and drops the output.

module rational_arithmetic_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_op,
    input  logic signed [31:0] i_left_num,
    input  logic [30:0]        i_left_den,
    input  logic signed [31:0] i_right_num,
    input  logic [30:0]        i_right_den,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_res_num,
    output logic [30:0]        o_res_den,
    output logic               o_is_less,
    output logic               o_is_equal,
    output logic               o_is_greater,
    output logic [1:0]         o_status
);

    localparam int W  = VALUE_WIDTH;
    localparam int NW = W + 1;           // multiplier operand width
    localparam int PW = 2 * NW;          // product width
    localparam int SW = PW + 1;          // sum width
    localparam int MW = 2 * W;           // magnitude width
    localparam int KW = $clog2(MW + 1);

    rau_pkg::t_state r_state, n_state;

    // Captured operands.
    logic [2:0]          r_op;
    logic signed [W-1:0] r_n1, r_n2;
    logic [W-2:0]        r_d1, r_d2;

    // Shared multiplier and its product registers.
    logic [1:0]           r_step;
    logic signed [NW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_p;
    logic signed [PW-1:0] r_x, r_y, r_dd, r_p3;

    // Reduction datapath.
    logic [MW-1:0] r_un, r_ud, r_a, r_b, r_g, r_qn;
    logic [KW-1:0] r_k;
    logic          r_neg, r_err, r_lt, r_eq, r_gt;

    // Output register.
    logic                r_out_valid;
    logic signed [W-1:0] r_res_num;
    logic [W-2:0]        r_res_den;
    logic                r_is_less, r_is_equal, r_is_greater;
    logic [1:0]          r_status;

    // Divider connection.
    logic          div_start, div_done;
    logic [MW-1:0] div_dividend, div_quot;

    logic signed [SW-1:0] s_n, s_d, s_n2, s_d2;
    logic                 s_err, s_dzero;
    logic [MW-1:0]        gcd_diff_ab, gcd_diff_ba;
    logic [MW-1:0]        lim;
    logic                 ovf, out_free;

    assign lim      = {{(MW - W + 1){1'b0}}, {(W - 1){1'b1}}};
    assign out_free = !r_out_valid || i_out_ready;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rau_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and sequencer outputs.
    always_comb begin
        n_state      = r_state;
        div_start    = 1'b0;
        div_dividend = r_un;
        unique case (r_state)
            rau_pkg::S_IDLE: begin
                if (i_in_valid) n_state = rau_pkg::S_MUL;
            end
            rau_pkg::S_MUL: begin
                if (r_step == 2'd3) n_state = rau_pkg::S_SETUP;
            end
            rau_pkg::S_SETUP: begin
                n_state = s_err ? rau_pkg::S_FIN : rau_pkg::S_GCD;
            end
            rau_pkg::S_GCD: begin
                if (r_a == '0 || r_b == '0) n_state = rau_pkg::S_SHIFT;
            end
            rau_pkg::S_SHIFT: begin
                if (r_k == '0) n_state = rau_pkg::S_DIVN_GO;
            end
            rau_pkg::S_DIVN_GO: begin
                div_start = 1'b1;
                n_state   = rau_pkg::S_DIVN_WAIT;
            end
            rau_pkg::S_DIVN_WAIT: begin
                if (div_done) n_state = rau_pkg::S_DIVD_GO;
            end
            rau_pkg::S_DIVD_GO: begin
                div_start    = 1'b1;
                div_dividend = r_ud;
                n_state      = rau_pkg::S_DIVD_WAIT;
            end
            rau_pkg::S_DIVD_WAIT: begin
                div_dividend = r_ud;
                if (div_done) n_state = rau_pkg::S_FIN;
            end
            rau_pkg::S_FIN: begin
                if (out_free) n_state = rau_pkg::S_IDLE;
            end
            default: n_state = rau_pkg::S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == rau_pkg::S_IDLE);

    // Multiplier operand selection: n1*d2, n2*d1, d1*d2, then n1*n2 or d1*n2.
    always_comb begin
        unique case (r_step)
            2'd0: begin
                mul_a = NW'(r_n1);
                mul_b = $signed({2'b00, r_d2});
            end
            2'd1: begin
                mul_a = NW'(r_n2);
                mul_b = $signed({2'b00, r_d1});
            end
            2'd2: begin
                mul_a = $signed({2'b00, r_d1});
                mul_b = $signed({2'b00, r_d2});
            end
            default: begin
                mul_a = (r_op == rau_pkg::OP_MUL) ? NW'(r_n1) : $signed({2'b00, r_d1});
                mul_b = NW'(r_n2);
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Operation decode into a signed numerator and denominator.
    always_comb begin
        s_dzero = (r_d1 == '0) || (r_d2 == '0);
        s_err   = s_dzero;
        s_n     = '0;
        s_d     = SW'(1);
        unique case (r_op)
            rau_pkg::OP_ADD: begin
                s_n = SW'(r_x) + SW'(r_y);
                s_d = SW'(r_dd);
            end
            rau_pkg::OP_SUB: begin
                s_n = SW'(r_x) - SW'(r_y);
                s_d = SW'(r_dd);
            end
            rau_pkg::OP_MUL: begin
                s_n = SW'(r_p3);
                s_d = SW'(r_dd);
            end
            rau_pkg::OP_DIV: begin
                s_n = SW'(r_x);
                s_d = SW'(r_p3);
                if (r_n2 == '0) s_err = 1'b1;
            end
            rau_pkg::OP_INV: begin
                s_n = $signed({{(SW - W + 1){1'b0}}, r_d1});
                s_d = SW'(r_n1);
                if (r_n1 == '0) s_err = 1'b1;
            end
            rau_pkg::OP_NEG: begin
                s_n = -SW'(r_n1);
                s_d = $signed({{(SW - W + 1){1'b0}}, r_d1});
            end
            default: s_err = 1'b1;
        endcase
        // Move the sign onto the numerator.
        s_n2 = s_d[SW-1] ? -s_n : s_n;
        s_d2 = s_d[SW-1] ? -s_d : s_d;
    end

    assign gcd_diff_ab = r_a - r_b;
    assign gcd_diff_ba = r_b - r_a;

    // Saturation check on the reduced pair.
    assign ovf = (div_quot > lim) || (!r_neg && r_qn > lim) || (r_neg && r_qn > lim + 1'b1);

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            unique case (r_state)
                rau_pkg::S_IDLE: begin
                    r_step <= '0;
                end
                rau_pkg::S_MUL: begin
                    r_step <= r_step + 1'b1;
                end
                default: begin
                    r_step <= r_step;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            rau_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    r_op <= i_op;
                    r_n1 <= i_left_num[W-1:0];
                    r_n2 <= i_right_num[W-1:0];
                    r_d1 <= i_left_den[W-2:0];
                    r_d2 <= i_right_den[W-2:0];
                end
            end
            rau_pkg::S_MUL: begin
                unique case (r_step)
                    2'd0:    r_x  <= mul_p;
                    2'd1:    r_y  <= mul_p;
                    2'd2:    r_dd <= mul_p;
                    default: r_p3 <= mul_p;
                endcase
            end
            rau_pkg::S_SETUP: begin
                r_err <= s_err;
                r_lt  <= !s_dzero && (r_x < r_y);
                r_eq  <= !s_dzero && (r_x == r_y);
                r_gt  <= !s_dzero && (r_x > r_y);
                r_neg <= s_n2[SW-1];
                r_un  <= s_n2[SW-1] ? MW'(-s_n2) : MW'(s_n2);
                r_ud  <= MW'(s_d2);
                r_a   <= s_n2[SW-1] ? MW'(-s_n2) : MW'(s_n2);
                r_b   <= MW'(s_d2);
                r_k   <= '0;
            end
            rau_pkg::S_GCD: begin
                // Binary GCD: strip common twos, then subtract the smaller.
                if (r_a == '0) begin
                    r_g <= r_b;
                end else if (r_b == '0) begin
                    r_g <= r_a;
                end else if (!r_a[0] && !r_b[0]) begin
                    r_a <= r_a >> 1;
                    r_b <= r_b >> 1;
                    r_k <= r_k + 1'b1;
                end else if (!r_a[0]) begin
                    r_a <= r_a >> 1;
                end else if (!r_b[0]) begin
                    r_b <= r_b >> 1;
                end else if (r_a >= r_b) begin
                    r_a <= gcd_diff_ab;
                end else begin
                    r_b <= gcd_diff_ba;
                end
            end
            rau_pkg::S_SHIFT: begin
                if (r_k != '0) begin
                    r_g <= r_g << 1;
                    r_k <= r_k - 1'b1;
                end
            end
            rau_pkg::S_DIVN_WAIT: begin
                if (div_done) r_qn <= div_quot;
            end
            default: begin
            end
        endcase
    end

    // Divider shared by the numerator and denominator reductions.
    rau_div #(
        .WIDTH(MW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_g),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Output register; the final denominator quotient is still held by the divider.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == rau_pkg::S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rau_pkg::S_FIN && out_free) begin
            r_is_less    <= r_lt;
            r_is_equal   <= r_eq;
            r_is_greater <= r_gt;
            if (r_err) begin
                r_status  <= rau_pkg::ST_ZERO;
                r_res_num <= '0;
                r_res_den <= (W - 1)'(1);
            end else if (ovf) begin
                r_status  <= rau_pkg::ST_OVF;
                r_res_num <= r_neg ? $signed({1'b1, {(W - 1){1'b0}}})
                                   : $signed({1'b0, {(W - 1){1'b1}}});
                r_res_den <= (W - 1)'(1);
            end else begin
                r_status  <= rau_pkg::ST_OK;
                r_res_num <= r_neg ? -$signed(r_qn[W-1:0]) : $signed(r_qn[W-1:0]);
                r_res_den <= div_quot[W-2:0];
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_res_num    = 32'(r_res_num);
    assign o_res_den    = 31'(r_res_den);
    assign o_is_less    = r_is_less;
    assign o_is_equal   = r_is_equal;
    assign o_is_greater = r_is_greater;
    assign o_status     = r_status;

endmodule

// ===== rtl/rau_checker.sv =====
`timescale 1ns / 1ps

module rau_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic [2:0]         i_op,
    input logic signed [31:0] i_left_num,
    input logic [30:0]        i_left_den,
    input logic signed [31:0] i_right_num,
    input logic [30:0]        i_right_den,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] o_res_num,
    input logic [30:0]        o_res_den,
    input logic               o_is_less,
    input logic               o_is_equal,
    input logic               o_is_greater,
    input logic [1:0]         o_status
);

    // A waiting result holds still.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_res_num) && $stable(o_status))
        else $error("result changed while stalled");

    // The unit drops its ready once it has taken a request.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while busy");

    // A zero denominator clears the flags; outside zero-status results exactly one compare flag is set.
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != rau_pkg::ST_ZERO
            |-> $onehot({o_is_less, o_is_equal, o_is_greater}))
        else $error("compare flags not one-hot");

    // Error and saturated results carry a denominator of one.
    a_err_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != rau_pkg::ST_OK |-> o_res_den == 31'd1)
        else $error("error result denominator not one");

    // A good result never has a zero denominator.
    a_ok_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == rau_pkg::ST_OK |-> o_res_den != 31'd0)
        else $error("zero denominator in result");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);
